// ===== rtl/core/ptmu_pkg.sv =====
// ptmu_pkg: constants, memory word and request types of the page table map/unmap core
// used by every module in rtl/core; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package ptmu_pkg;

  // number of page tables held on chip
  localparam int TABLE_SLOTS = 16;
  localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

  localparam int DIR_AW      = 10;
  localparam int DIR_DEPTH   = 1 << DIR_AW;
  localparam int TIDX_W      = 10;
  localparam int TBL_DEPTH   = TABLE_SLOTS << TIDX_W;
  localparam int TBL_AW      = SLOT_W + TIDX_W;

  localparam int FRAME_W     = 20;
  localparam int FLAG_W      = 12;
  localparam int PAGE_W      = 20;
  localparam int ENTRY_W     = 32;

  localparam int PRESENT_BIT = 0;
  localparam int GLOBAL_BIT  = 8;

  localparam logic KIND_MAP   = 1'b0;
  localparam logic KIND_UNMAP = 1'b1;

  // floor(2^32 / TABLE_SLOTS), used for the frame modulo
  localparam logic [32:0] SLOT_RECIP = 33'((64'd1 << 32) / TABLE_SLOTS);

  // directory word: only the present bit and the table slot are ever looked at
  typedef struct packed {
    logic              present;
    logic [SLOT_W-1:0] slot;
  } dir_word_t;

  typedef struct packed {
    logic              re;
    logic              we;
    logic [DIR_AW-1:0] addr;
    dir_word_t         wdata;
  } dir_req_t;

  // table word: only the present bit is ever looked at
  typedef struct packed {
    logic              re;
    logic              we;
    logic [TBL_AW-1:0] addr;
    logic              wdata;
  } tbl_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/ptmu_slot_calc.sv =====
// ptmu_slot_calc: table slot = table frame modulo TABLE_SLOTS, by reciprocal multiply
// depends on ptmu_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptmu_slot_calc (
  input  wire logic                          clk,
  input  wire logic                          load,
  input  wire logic [ptmu_pkg::FRAME_W-1:0]  frame,
  output logic      [ptmu_pkg::SLOT_W-1:0]   slot
);

  localparam int PROD_W = ptmu_pkg::FRAME_W + 33;

  logic [ptmu_pkg::FRAME_W-1:0] frame_r;
  logic [PROD_W-1:0]            prod_r;
  logic [PROD_W-33:0]           quot;
  logic [31:0]                  qd;
  logic [31:0]                  rem;
  logic [31:0]                  rem_fix;

  always_ff @(posedge clk) begin
    if (load) begin
      frame_r <= frame;
      prod_r  <= PROD_W'(frame) * PROD_W'(ptmu_pkg::SLOT_RECIP);
    end
  end

  // estimate is exact or one low, so one correction step suffices
  always_comb begin
    quot    = prod_r[PROD_W-1:32];
    qd      = 32'(quot) * 32'(ptmu_pkg::TABLE_SLOTS);
    rem     = 32'(frame_r) - qd;
    rem_fix = (rem >= 32'(ptmu_pkg::TABLE_SLOTS)) ? rem - 32'(ptmu_pkg::TABLE_SLOTS) : rem;
    slot    = rem_fix[ptmu_pkg::SLOT_W-1:0];
  end

endmodule

`default_nettype wire

// ===== rtl/core/ptmu_dir_store.sv =====
// ptmu_dir_store: page directory memory, one port, registered read
// depends on ptmu_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptmu_dir_store (
  input  wire logic                clk,
  input  wire ptmu_pkg::dir_req_t  req,
  output ptmu_pkg::dir_word_t      rdata
);

  ptmu_pkg::dir_word_t mem [0:ptmu_pkg::DIR_DEPTH-1];
  ptmu_pkg::dir_word_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/core/ptmu_tbl_store.sv =====
// ptmu_tbl_store: page table memory holding the present bit of every table entry
// depends on ptmu_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptmu_tbl_store (
  input  wire logic                clk,
  input  wire ptmu_pkg::tbl_req_t  req,
  output logic                     rdata
);

  logic mem [0:ptmu_pkg::TBL_DEPTH-1];
  logic rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/core/page_table_map_unmap_core.sv =====
// page_table_map_unmap_core: top level, request sequencer around directory and table memories
// depends on ptmu_pkg, ptmu_slot_calc, ptmu_dir_store, ptmu_tbl_store
`timescale 1ns / 1ps
`default_nettype none

// usage
//   a request (in_kind, in_virt_addr, in_phys_addr, in_table_addr, in_flags) is
//   taken at a rising edge with start high and busy low
//   every request gives exactly one result, shown for one cycle with out_valid
//   high; the receiver cannot stall, so results are never held back
// timing
//   map: accept edge, then the directory step reads the directory and writes the
//   table; result strobe in the cycle after that step, and a new request is
//   taken only once the previous one has finished (busy low)
//   unmap: when the directory entry is absent the result follows the directory
//   step; otherwise an extra table step reads the table entry before the clear
//   the steps are set by the registered read of the directory memory,
//   whose entry decides the table slot, and for unmap also of the table memory
// reset
//   rst_n low clears control state; afterwards a clearing pass zeroes both
//   memories, one entry a cycle, across TABLE_SLOTS * 1024 table entries (16384 here)
//   with busy high; the directory is covered within the same sweep
module page_table_map_unmap_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_kind,
  input  wire logic [31:0]                   in_virt_addr,
  input  wire logic [31:0]                   in_phys_addr,
  input  wire logic [31:0]                   in_table_addr,
  input  wire logic [ptmu_pkg::FLAG_W-1:0]   in_flags,
  output logic                               out_valid,
  output logic                               out_dir_created,
  output logic                               out_entry_changed,
  output logic                               out_invalidate,
  output logic      [ptmu_pkg::PAGE_W-1:0]   out_invalidate_page,
  output logic      [ptmu_pkg::ENTRY_W-1:0]  out_entry_value
);

  // sequencer states
  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_DIR   = 2'd2;
  localparam logic [1:0] S_TBL   = 2'd3;

  logic [1:0]                      state_r, state_nxt;
  logic [ptmu_pkg::TBL_AW-1:0]     clr_r, clr_nxt;

  // latched request
  logic                            kind_r, kind_nxt;
  logic [ptmu_pkg::PAGE_W-1:0]     page_r, page_nxt;
  logic [ptmu_pkg::FRAME_W-1:0]    pframe_r, pframe_nxt;
  logic [ptmu_pkg::FLAG_W-1:0]     flags_r, flags_nxt;
  logic [ptmu_pkg::SLOT_W-1:0]     slot_r, slot_nxt;

  // result register
  logic                            out_valid_r, out_valid_nxt;
  logic                            created_r, created_nxt;
  logic                            changed_r, changed_nxt;
  logic                            inval_r, inval_nxt;
  logic [ptmu_pkg::PAGE_W-1:0]     opage_r, opage_nxt;
  logic [ptmu_pkg::ENTRY_W-1:0]    value_r, value_nxt;

  ptmu_pkg::dir_req_t              dir_req;
  ptmu_pkg::dir_word_t             dir_rd;
  ptmu_pkg::tbl_req_t              tbl_req;
  logic                            tbl_rd;
  logic                            slot_load;
  logic [ptmu_pkg::SLOT_W-1:0]     new_slot;
  logic [ptmu_pkg::SLOT_W-1:0]     use_slot;
  logic [ptmu_pkg::TIDX_W-1:0]     tidx;

  assign tidx = page_r[ptmu_pkg::TIDX_W-1:0];

  // modulo of the table frame runs alongside the directory read
  ptmu_slot_calc u_slot (
    .clk   (clk),
    .load  (slot_load),
    .frame (in_table_addr[31:12]),
    .slot  (new_slot)
  );

  ptmu_dir_store u_dir (
    .clk   (clk),
    .req   (dir_req),
    .rdata (dir_rd)
  );

  ptmu_tbl_store u_tbl (
    .clk   (clk),
    .req   (tbl_req),
    .rdata (tbl_rd)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    kind_nxt      = kind_r;
    page_nxt      = page_r;
    pframe_nxt    = pframe_r;
    flags_nxt     = flags_r;
    slot_nxt      = slot_r;
    out_valid_nxt = 1'b0;
    created_nxt   = created_r;
    changed_nxt   = changed_r;
    inval_nxt     = inval_r;
    opage_nxt     = opage_r;
    value_nxt     = value_r;
    dir_req       = '0;
    tbl_req       = '0;
    slot_load     = 1'b0;
    use_slot      = dir_rd.present ? dir_rd.slot : new_slot;

    case (state_r)
      S_CLEAR: begin
        // zero one table entry and one directory entry a cycle
        dir_req.we   = 1'b1;
        dir_req.addr = clr_r[ptmu_pkg::DIR_AW-1:0];
        tbl_req.we   = 1'b1;
        tbl_req.addr = clr_r;
        clr_nxt      = clr_r + 1'b1;
        if (clr_r == ptmu_pkg::TBL_AW'(ptmu_pkg::TBL_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          kind_nxt     = in_kind;
          page_nxt     = in_virt_addr[31:12];
          pframe_nxt   = in_phys_addr[31:12];
          flags_nxt    = in_flags;
          slot_load    = 1'b1;
          dir_req.re   = 1'b1;
          dir_req.addr = in_virt_addr[31:22];
          state_nxt    = S_DIR;
        end
      end

      S_DIR: begin
        opage_nxt = page_r;
        if (kind_r == ptmu_pkg::KIND_MAP) begin
          // absent directory entry: install the new table, present bit from flags
          if (!dir_rd.present) begin
            dir_req.we            = 1'b1;
            dir_req.addr          = page_r[ptmu_pkg::PAGE_W-1:ptmu_pkg::TIDX_W];
            dir_req.wdata.present = flags_r[ptmu_pkg::PRESENT_BIT];
            dir_req.wdata.slot    = new_slot;
          end
          tbl_req.we    = 1'b1;
          tbl_req.addr  = {use_slot, tidx};
          tbl_req.wdata = flags_r[ptmu_pkg::PRESENT_BIT];
          created_nxt   = !dir_rd.present;
          changed_nxt   = 1'b1;
          inval_nxt     = flags_r[ptmu_pkg::GLOBAL_BIT];
          value_nxt     = {pframe_r, flags_r};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (dir_rd.present) begin
          // unmap under a present directory entry: look at the table entry
          tbl_req.re   = 1'b1;
          tbl_req.addr = {dir_rd.slot, tidx};
          slot_nxt     = dir_rd.slot;
          state_nxt    = S_TBL;
        end else begin
          created_nxt   = 1'b0;
          changed_nxt   = 1'b0;
          inval_nxt     = 1'b0;
          value_nxt     = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_TBL: begin
        if (tbl_rd) begin
          tbl_req.we   = 1'b1;
          tbl_req.addr = {slot_r, tidx};
        end
        created_nxt   = 1'b0;
        changed_nxt   = tbl_rd;
        inval_nxt     = tbl_rd;
        value_nxt     = '0;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    page_r    <= page_nxt;
    pframe_r  <= pframe_nxt;
    flags_r   <= flags_nxt;
    slot_r    <= slot_nxt;
    created_r <= created_nxt;
    changed_r <= changed_nxt;
    inval_r   <= inval_nxt;
    opage_r   <= opage_nxt;
    value_r   <= value_nxt;
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_dir_created     = created_r;
  assign out_entry_changed   = changed_r;
  assign out_invalidate      = inval_r;
  assign out_invalidate_page = opage_r;
  assign out_entry_value     = value_r;

`ifndef NO_ASSERTIONS
  // a result only follows a directory or table step
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == S_DIR || $past(state_r) == S_TBL))
    else $error("result strobe without a finished request");

  // an accepted request always goes to the directory step
  a_accept_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_DIR))
    else $error("accepted request did not start the directory step");

  // a created directory entry always comes with a written table entry
  a_created_changed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_dir_created) |-> out_entry_changed)
    else $error("directory entry created without table write");

  // memories are never written while idle
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!tbl_req.we && !dir_req.we))
    else $error("memory write while idle");

  // an unmap that clears an entry always asks for an invalidate and reports zero
  a_unmap_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TBL && tbl_rd) |=> (out_valid && out_invalidate && out_entry_value == '0))
    else $error("unmap clear result wrong");
`endif

endmodule

`default_nettype wire
